// ===== design/spa_pkg.sv =====
// shared types and constants of the shear projection accumulator
package spa_pkg;

	localparam int FRAC_BITS   = 14;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;

	localparam int COORD_W   = 8;
	localparam int DIM_W     = 9;
	localparam int COEF_W    = 16;
	localparam int BIDX_W    = 9;
	localparam int SUM_W     = 40;
	localparam int PROD_W    = COEF_W + SAMPLE_BITS;
	localparam int CONTRIB_W = PROD_W + 1;
	localparam int SHEARP_W  = COEF_W + COORD_W + 1;
	localparam int OMF_W     = COEF_W + 2;
	localparam int NUM_W     = DIM_W + 1 + OMF_W;
	localparam int START_W   = NUM_W - FRAC_BITS - 1;
	localparam int CALC_W    = START_W + 2;

	localparam int FIFO_DEPTH = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_MODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR_FACTOR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_COS      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SIN      = 3'd5;

	typedef struct packed {
		logic [DIM_W-1:0]         image_width;
		logic [DIM_W-1:0]         image_height;
		logic                     horizontal_mode;
		logic signed [COEF_W-1:0] shear_factor;
		logic signed [COEF_W-1:0] weight_cos;
		logic signed [COEF_W-1:0] weight_sin;
	} cfg_t;

	typedef struct packed {
		logic             touched;
		logic [SUM_W-1:0] sum;
	} entry_t;

endpackage

// ===== design/spa_index_calc.sv =====
// bin address and weighted contribution of each word, three register stages
module spa_index_calc
	import spa_pkg::*;
#(
	parameter int BIN_COUNT = 512,
	parameter int ADDR_W    = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_read,
	input  logic [COORD_W-1:0]          in_col,
	input  logic [COORD_W-1:0]          in_row,
	input  logic signed [SAMPLE_BITS-1:0] in_sample_x,
	input  logic signed [SAMPLE_BITS-1:0] in_sample_y,
	input  logic [BIDX_W-1:0]           in_bin_index,
	input  cfg_t                        cfg,
	output logic                        valid_s3,
	output logic                        read_s3,
	output logic [ADDR_W-1:0]           addr_s3,
	output logic signed [CONTRIB_W-1:0] contrib_s3
);

	// line start, depends on configuration only
	logic [DIM_W-1:0]         extent;
	logic signed [OMF_W-1:0]  omf;
	logic signed [NUM_W-1:0]  num;
	logic signed [NUM_W-1:0]  num_adj;
	logic signed [START_W-1:0] start_q;

	always_comb begin
		extent  = cfg.horizontal_mode ? cfg.image_height : cfg.image_width;
		omf     = OMF_W'(1 << FRAC_BITS) - OMF_W'(cfg.shear_factor);
		num     = NUM_W'($signed({1'b0, extent})) * NUM_W'(omf);
		num_adj = num[NUM_W-1] ? num + NUM_W'((1 << (FRAC_BITS + 1)) - 1) : num;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else begin
			start_q <= START_W'(num_adj >>> (FRAC_BITS + 1));
		end
	end

	// stage 1: registered word
	logic                         valid_s1, read_s1;
	logic [COORD_W-1:0]           col_s1, row_s1;
	logic signed [SAMPLE_BITS-1:0] sx_s1, sy_s1;
	logic [BIDX_W-1:0]            bidx_s1;

	// stage 2: products
	logic                         valid_s2, read_s2;
	logic [COORD_W-1:0]           pos_s2;
	logic [BIDX_W-1:0]            bidx_s2;
	logic signed [SHEARP_W-1:0]   shp_s2;
	logic signed [PROD_W-1:0]     mc_s2, ms_s2;

	logic                         inside_s1;
	logic [COORD_W-1:0]           pos_s1, idx_s1;
	logic signed [SHEARP_W-1:0]   shp_s1;
	logic signed [PROD_W-1:0]     mc_s1, ms_s1;

	always_comb begin
		inside_s1 = (DIM_W'(col_s1) < cfg.image_width) && (DIM_W'(row_s1) < cfg.image_height);
		pos_s1    = cfg.horizontal_mode ? col_s1 : row_s1;
		idx_s1    = cfg.horizontal_mode ? row_s1 : col_s1;
		shp_s1    = SHEARP_W'(cfg.shear_factor) * SHEARP_W'($signed({1'b0, idx_s1}));
		mc_s1     = PROD_W'(cfg.weight_cos) * PROD_W'(sx_s1);
		ms_s1     = PROD_W'(cfg.weight_sin) * PROD_W'(sy_s1);
	end

	// stage 2 logic: rounding of the shear term, bin, sum of products
	logic                        neg_s2;
	logic [SHEARP_W-1:0]         mag_s2, rnd_s2;
	logic signed [CALC_W-1:0]    r_s2, bin_s2;
	logic                        bin_ok_s2;
	logic signed [CONTRIB_W-1:0] contrib_s2;

	always_comb begin
		neg_s2     = shp_s2[SHEARP_W-1];
		mag_s2     = neg_s2 ? SHEARP_W'(-shp_s2) : SHEARP_W'(shp_s2);
		rnd_s2     = (mag_s2 + SHEARP_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		r_s2       = neg_s2 ? -$signed(CALC_W'(rnd_s2)) : $signed(CALC_W'(rnd_s2));
		bin_s2     = $signed(CALC_W'(pos_s2)) + CALC_W'(start_q) + r_s2;
		bin_ok_s2  = !bin_s2[CALC_W-1] && (bin_s2 < CALC_W'(BIN_COUNT));
		contrib_s2 = CONTRIB_W'(mc_s2) + CONTRIB_W'(ms_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && (read_s1 || inside_s1);
			valid_s3 <= valid_s2 && (read_s2 || bin_ok_s2);
		end
	end

	always_ff @(posedge clk) begin
		read_s1    <= in_read;
		col_s1     <= in_col;
		row_s1     <= in_row;
		sx_s1      <= in_sample_x;
		sy_s1      <= in_sample_y;
		bidx_s1    <= in_bin_index;

		read_s2    <= read_s1;
		pos_s2     <= pos_s1;
		bidx_s2    <= bidx_s1;
		shp_s2     <= shp_s1;
		mc_s2      <= mc_s1;
		ms_s2      <= ms_s1;

		read_s3    <= read_s2;
		addr_s3    <= read_s2 ? ADDR_W'(bidx_s2) : ADDR_W'(bin_s2);
		contrib_s3 <= contrib_s2;
	end

endmodule

// ===== design/spa_bin_ram.sv =====
// bin memory, one write and one registered read port
module spa_bin_ram
	import spa_pkg::*;
#(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/spa_result_fifo.sv =====
// small result queue in front of the output channel
module spa_result_fifo
	import spa_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   out_valid,
	input  logic   out_ready,
	output entry_t out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t            slots [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign out_data  = slots[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/shear_projection_accumulator.sv =====
// top level of the shear projection accumulator
// usage:
//  - configure size, orientation, shear factor and cos/sin weights through the
//    cfg_we/cfg_index/cfg_data write port while the block is idle
//  - each input word on s_* is either a pixel (s_tuser = 0) that adds
//    cos*sample_x + sin*sample_y to the bin its sheared position lands in, or a
//    bin read (s_tuser = 1) that returns the bin's sum and touched flag on m_*
//    and clears the bin; pixels outside the image or bins out of range are dropped
//  - throughput is one word per cycle while s_tready is high: every word is a
//    single read-modify-write of the bin memory, with the last write forwarded
//    into the next word
//  - m_tvalid follows the three index and product stages (the first loads on
//    the accepting edge), one memory read, then the update and the buffer push
//  - after reset a clearing pass writes zero to every bin with s_tready low;
//    configuration writes are still taken during the pass
//  - results queue in an eight-word buffer; s_tready drops only when the buffer
//    plus the reads in flight would fill it, so a stalled receiver holds nothing
//    back until eight reads are pending
module shear_projection_accumulator
	import spa_pkg::*;
#(
	parameter int BIN_COUNT = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,   // col, row, sample_x, sample_y, bin_index, pad
	input  logic [0:0]            s_tuser,   // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [SUM_W-1:0]      m_tdata,   // bin_sum
	output logic [0:0]            m_tuser,   // bin_valid
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int RES_W  = $clog2(FIFO_DEPTH + 1);

	// configuration registers
	cfg_t             cfg_q;
	logic [DIM_W-1:0] cfg_dim;

	assign cfg_dim = cfg_data[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= DIM_W'(MAX_WIDTH);
			cfg_q.image_height    <= DIM_W'(MAX_HEIGHT);
			cfg_q.horizontal_mode <= 1'b1;
			cfg_q.shear_factor    <= '0;
			cfg_q.weight_cos      <= COEF_W'(1 << FRAC_BITS);
			cfg_q.weight_sin      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= (int'(cfg_dim) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg_dim;
				end
				REG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= (int'(cfg_dim) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg_dim;
				end
				REG_HORIZONTAL_MODE: begin
					cfg_q.horizontal_mode <= cfg_data[0];
				end
				REG_SHEAR_FACTOR: begin
					cfg_q.shear_factor <= $signed(cfg_data);
				end
				REG_WEIGHT_COS: begin
					cfg_q.weight_cos <= $signed(cfg_data);
				end
				REG_WEIGHT_SIN: begin
					cfg_q.weight_sin <= $signed(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// input word fields
	logic                        in_read;
	logic [COORD_W-1:0]          in_col, in_row;
	logic signed [SAMPLE_BITS-1:0] in_sx, in_sy;
	logic [BIDX_W-1:0]           in_bidx;
	logic                        accept, read_ok;

	assign in_read = s_tuser[0];
	assign in_col  = s_tdata[7:0];
	assign in_row  = s_tdata[15:8];
	assign in_sx   = $signed(s_tdata[31:16]);
	assign in_sy   = $signed(s_tdata[47:32]);
	assign in_bidx = s_tdata[56:48];

	assign accept  = s_tvalid && s_tready;
	// reads beyond the bin range vanish at the door
	assign read_ok = int'(in_bidx) < BIN_COUNT;

	// clearing pass after reset
	logic              clr_active_q;
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(BIN_COUNT - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// result slots reserved by reads accepted but not yet delivered
	logic [RES_W-1:0] res_cnt_q;
	logic             res_take, res_give;

	assign res_take = accept && in_read && read_ok;
	assign res_give = m_tvalid && m_tready;
	assign s_tready = !clr_active_q && (res_cnt_q < RES_W'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (res_take && !res_give) begin
			res_cnt_q <= res_cnt_q + 1'b1;
		end else if (res_give && !res_take) begin
			res_cnt_q <= res_cnt_q - 1'b1;
		end
	end

	// index and product stages
	logic                        valid_s3, read_s3;
	logic [ADDR_W-1:0]           addr_s3;
	logic signed [CONTRIB_W-1:0] contrib_s3;

	spa_index_calc #(
		.BIN_COUNT (BIN_COUNT),
		.ADDR_W    (ADDR_W)
	) u_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept && (!in_read || read_ok)),
		.in_read      (in_read),
		.in_col       (in_col),
		.in_row       (in_row),
		.in_sample_x  (in_sx),
		.in_sample_y  (in_sy),
		.in_bin_index (in_bidx),
		.cfg          (cfg_q),
		.valid_s3     (valid_s3),
		.read_s3      (read_s3),
		.addr_s3      (addr_s3),
		.contrib_s3   (contrib_s3)
	);

	// bin memory: read in s3, update and write back in s4
	logic                        we;
	logic [ADDR_W-1:0]           waddr;
	entry_t                      wdata, rdata;

	logic                        valid_s4, read_s4;
	logic [ADDR_W-1:0]           addr_s4;
	logic signed [CONTRIB_W-1:0] contrib_s4;

	// last write, forwarded when the next word hits the same bin
	logic              wr_en_q;
	logic [ADDR_W-1:0] wr_addr_q;
	entry_t            wr_data_q;

	entry_t old_s4, new_s4;

	spa_bin_ram #(
		.DEPTH  (BIN_COUNT),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr_s3),
		.rdata (rdata)
	);

	always_comb begin
		old_s4 = (wr_en_q && (wr_addr_q == addr_s4)) ? wr_data_q : rdata;
		if (read_s4) begin
			new_s4 = '0;
		end else begin
			new_s4.touched = 1'b1;
			new_s4.sum     = old_s4.sum + SUM_W'(contrib_s4);
		end
		we    = clr_active_q || valid_s4;
		waddr = clr_active_q ? clr_addr_q : addr_s4;
		wdata = clr_active_q ? entry_t'('0) : new_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			wr_en_q  <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			wr_en_q  <= we;
		end
	end

	always_ff @(posedge clk) begin
		read_s4    <= read_s3;
		addr_s4    <= addr_s3;
		contrib_s4 <= contrib_s3;
		wr_addr_q  <= waddr;
		wr_data_q  <= wdata;
	end

	// results of reads leave through the queue
	entry_t out_entry;

	spa_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s4 && read_s4),
		.push_data (old_s4),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_entry)
	);

	assign m_tdata    = out_entry.sum;
	assign m_tuser[0] = out_entry.touched;

endmodule
